@@ hdl/ltr_pkg.sv @@
// shared types, mode codes and channel widening functions for the texel converter
`default_nettype none
package ltr_pkg;

  localparam int unsigned ModeW  = 3;
  localparam int unsigned TexelW = 24;
  localparam int unsigned ChanW  = 8;

  typedef enum logic [ModeW-1:0] {
    MODE_BGR888   = 3'd0,
    MODE_RGB332   = 3'd1,
    MODE_ARGB8332 = 3'd2,
    MODE_ARGB4444 = 3'd3,
    MODE_XRGB4444 = 3'd4,
    MODE_LA44     = 3'd5
  } src_mode_t;

  typedef struct packed {
    logic [ChanW-1:0] red;
    logic [ChanW-1:0] green;
    logic [ChanW-1:0] blue;
    logic [ChanW-1:0] alpha;
  } rgba_t;

  localparam logic [ChanW-1:0] ChanMax = 8'hFF;

  // round(v*255/3) is v*85: the two bits repeated four times
  function automatic logic [ChanW-1:0] widen2(input logic [1:0] v);
    widen2 = {v, v, v, v};
  endfunction

  // round(v*255/7) equals bit replication for all eight codes
  function automatic logic [ChanW-1:0] widen3(input logic [2:0] v);
    widen3 = {v, v, v[2:1]};
  endfunction

  // v*255/15 is exactly v*17
  function automatic logic [ChanW-1:0] widen4(input logic [3:0] v);
    widen4 = {v, v};
  endfunction

endpackage
`default_nettype wire

@@ hdl/legacy_texel_to_rgba8.sv @@
// top level: legacy packed texel to rgba8 converter
`default_nettype none
// Converts one packed legacy texel (up to three bytes, byte 0 in bits 7:0)
// into one RGBA8 texel per request. The format comes from the mode register
// written over the cfg_ port: 0 bgr888, 1 rgb332, 2 argb8332, 3 argb4444,
// 4 xrgb4444, 5 luminance/alpha 4-4; codes 6 and 7 give an all-zero pixel.
// Narrow channels widen by round-to-nearest v*255/max, missing alpha reads
// 255. The datapath is two registers deep: a request is captured in an
// input register, converted by shallow per-channel bit replication, and
// lands in the output register; the block sustains one request per clock
// while the consumer is not stalling. in_stall
// rises only when both registers hold data and the consumer is stalling.
// Write the mode only while no requests are in flight.
module legacy_texel_to_rgba8 (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  // configuration
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [ltr_pkg::ModeW-1:0]  cfg_data,
  // texel requests
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [ltr_pkg::TexelW-1:0] in_texel_bytes,
  // rgba8 results
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic      [ltr_pkg::ChanW-1:0]  out_red,
  output logic      [ltr_pkg::ChanW-1:0]  out_green,
  output logic      [ltr_pkg::ChanW-1:0]  out_blue,
  output logic      [ltr_pkg::ChanW-1:0]  out_alpha
);
  import ltr_pkg::*;

  logic [ModeW-1:0]  mode;

  // input stage
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [TexelW-1:0] s1_texel_r;

  // output stage
  logic              out_valid_r;
  logic              out_valid_nxt;
  rgba_t             out_pix_r;
  rgba_t             conv_pix;

  logic              out_adv;
  logic              s1_adv;

  ltr_mode_reg u_mode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .mode      (mode)
  );

  ltr_convert u_conv (
    .mode  (mode),
    .texel (s1_texel_r),
    .pix   (conv_pix)
  );

  // output register may load when empty or when its pixel is being taken
  assign out_adv = !out_valid_r || !out_stall;
  // input register may load when empty or when it can move forward
  assign s1_adv  = !s1_valid_r || out_adv;
  assign in_stall = !s1_adv;

  always_comb begin
    s1_valid_nxt  = s1_valid_r;
    out_valid_nxt = out_valid_r;
    if (out_adv) begin
      out_valid_nxt = s1_valid_r;
    end
    if (s1_adv) begin
      s1_valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (s1_adv && in_valid) begin
      s1_texel_r <= in_texel_bytes;
    end
    if (out_adv && s1_valid_r) begin
      out_pix_r <= conv_pix;
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r.red;
  assign out_green = out_pix_r.green;
  assign out_blue  = out_pix_r.blue;
  assign out_alpha = out_pix_r.alpha;

endmodule
`default_nettype wire

@@ hdl/ltr_mode_reg.sv @@
// source mode configuration register
`default_nettype none
module ltr_mode_reg (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [ltr_pkg::ModeW-1:0] cfg_data,
  output logic      [ltr_pkg::ModeW-1:0] mode
);
  import ltr_pkg::*;

  logic [ModeW-1:0] mode_r;
  logic [ModeW-1:0] mode_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_valid && cfg_ready) begin
      mode_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BGR888;
    end else begin
      mode_r <= mode_nxt;
    end
  end

  assign mode = mode_r;

endmodule
`default_nettype wire

@@ hdl/ltr_convert.sv @@
// combinational unpack and widen of one texel to rgba8
`default_nettype none
module ltr_convert (
  input  wire logic [ltr_pkg::ModeW-1:0]  mode,
  input  wire logic [ltr_pkg::TexelW-1:0] texel,
  output ltr_pkg::rgba_t                  pix
);
  import ltr_pkg::*;

  logic [7:0] b0;
  logic [7:0] b1;
  logic [7:0] b2;

  assign b0 = texel[7:0];
  assign b1 = texel[15:8];
  assign b2 = texel[23:16];

  always_comb begin
    pix = '0;
    unique case (mode)
      MODE_BGR888: begin
        pix.red   = b2;
        pix.green = b1;
        pix.blue  = b0;
        pix.alpha = ChanMax;
      end
      MODE_RGB332, MODE_ARGB8332: begin
        pix.red   = widen3(b0[7:5]);
        pix.green = widen3(b0[4:2]);
        pix.blue  = widen2(b0[1:0]);
        pix.alpha = (mode == MODE_ARGB8332) ? b1 : ChanMax;
      end
      MODE_ARGB4444, MODE_XRGB4444: begin
        pix.red   = widen4(b1[3:0]);
        pix.green = widen4(b0[7:4]);
        pix.blue  = widen4(b0[3:0]);
        pix.alpha = (mode == MODE_ARGB4444) ? widen4(b1[7:4]) : ChanMax;
      end
      MODE_LA44: begin
        pix.red   = widen4(b0[3:0]);
        pix.green = widen4(b0[3:0]);
        pix.blue  = widen4(b0[3:0]);
        pix.alpha = widen4(b0[7:4]);
      end
      // codes six and seven give all channels zero
      default: pix = '0;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/ltr_checker.sv @@
// port-level checker for the texel converter and its bind
`default_nettype none
module ltr_checker (
  input wire logic                       clk,
  input wire logic                       rst_n,
  input wire logic                       cfg_valid,
  input wire logic                       cfg_ready,
  input wire logic [ltr_pkg::ModeW-1:0]  cfg_data,
  input wire logic                       in_valid,
  input wire logic                       in_stall,
  input wire logic [ltr_pkg::TexelW-1:0] in_texel_bytes,
  input wire logic                       out_valid,
  input wire logic                       out_stall,
  input wire logic [ltr_pkg::ChanW-1:0]  out_red,
  input wire logic [ltr_pkg::ChanW-1:0]  out_green,
  input wire logic [ltr_pkg::ChanW-1:0]  out_blue,
  input wire logic [ltr_pkg::ChanW-1:0]  out_alpha
);
  import ltr_pkg::*;

  // shadow of the mode register as seen from the port
  logic [ModeW-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_BGR888;
    end else if (cfg_valid && cfg_ready) begin
      mode_r <= cfg_data;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
      && $stable(out_blue) && $stable(out_alpha))
    else $error("stalled result changed");

  // with nothing waiting at the output a request is never stalled
  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");

  // luminance mode gives grey pixels
  a_la44_grey: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r == MODE_LA44 |-> out_red == out_green && out_green == out_blue)
    else $error("luminance pixel not grey");

  // formats without alpha report opaque
  a_opaque: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (mode_r == MODE_BGR888 || mode_r == MODE_RGB332
      || mode_r == MODE_XRGB4444) |-> out_alpha == ChanMax)
    else $error("alpha not opaque for format without alpha");

  // unused mode codes give a zero pixel
  a_bad_mode_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && mode_r > MODE_LA44 |-> out_red == '0 && out_green == '0
      && out_blue == '0 && out_alpha == '0)
    else $error("unused mode gave nonzero pixel");

endmodule

bind legacy_texel_to_rgba8 ltr_checker u_ltr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .cfg_valid      (cfg_valid),
  .cfg_ready      (cfg_ready),
  .cfg_data       (cfg_data),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_texel_bytes (in_texel_bytes),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_red        (out_red),
  .out_green      (out_green),
  .out_blue       (out_blue),
  .out_alpha      (out_alpha)
);
`default_nettype wire

@@ sim/tb_top.sv @@
// testbench for the legacy texel to rgba8 converter, with its scoreboard class
`timescale 1ns / 1ps
module tb_top;
  import ltr_pkg::*;

  // expected rgba8 texels, worked out from the mode held at the time a request is taken
  class rgba_scoreboard;
    logic [ModeW-1:0] mode;
    rgba_t            pending_rgba[$];
    int unsigned      mismatches;
    int unsigned      checked;

    function new();
      mode       = MODE_BGR888;
      mismatches = 0;
      checked    = 0;
    endfunction

    // round-to-nearest v*255/maxv
    function automatic logic [ChanW-1:0] stretch(int unsigned v, int unsigned maxv);
      int unsigned s;
      s = (v * 255 + maxv / 2) / maxv;
      return s[ChanW-1:0];
    endfunction

    function automatic rgba_t texel_to_rgba(logic [ModeW-1:0] m, logic [TexelW-1:0] t);
      rgba_t px;
      px = '0;
      case (m) inside
        MODE_BGR888: begin
          px.red   = t[23:16];
          px.green = t[15:8];
          px.blue  = t[7:0];
          px.alpha = ChanMax;
        end
        MODE_RGB332, MODE_ARGB8332: begin
          px.red   = stretch(t[7:5], 7);
          px.green = stretch(t[4:2], 7);
          px.blue  = stretch(t[1:0], 3);
          px.alpha = (m == MODE_ARGB8332) ? t[15:8] : ChanMax;
        end
        MODE_ARGB4444, MODE_XRGB4444: begin
          px.red   = stretch(t[11:8], 15);
          px.green = stretch(t[7:4], 15);
          px.blue  = stretch(t[3:0], 15);
          px.alpha = (m == MODE_ARGB4444) ? stretch(t[15:12], 15) : ChanMax;
        end
        MODE_LA44: begin
          px.red   = stretch(t[3:0], 15);
          px.green = px.red;
          px.blue  = px.red;
          px.alpha = stretch(t[7:4], 15);
        end
        default: px = '0;
      endcase
      return px;
    endfunction

    function void note_request(logic [TexelW-1:0] t);
      pending_rgba = {pending_rgba, texel_to_rgba(mode, t)};
    endfunction

    function void check_result(rgba_t got);
      rgba_t want;
      if (pending_rgba.size() == 0) begin
        $error("result with nothing pending: %h", got);
        mismatches++;
        return;
      end
      want = pending_rgba.pop_front();
      checked++;
      if (got.red !== want.red) begin
        $error("red expected %0d actual %0d", want.red, got.red);
        mismatches++;
      end
      if (got.green !== want.green) begin
        $error("green expected %0d actual %0d", want.green, got.green);
        mismatches++;
      end
      if (got.blue !== want.blue) begin
        $error("blue expected %0d actual %0d", want.blue, got.blue);
        mismatches++;
      end
      if (got.alpha !== want.alpha) begin
        $error("alpha expected %0d actual %0d", want.alpha, got.alpha);
        mismatches++;
      end
    endfunction
  endclass

  logic              clk;
  logic              rst_n;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [ModeW-1:0]  cfg_data;
  logic              in_valid;
  logic              in_stall;
  logic [TexelW-1:0] in_texel_bytes;
  logic              out_valid;
  logic              out_stall;
  logic [ChanW-1:0]  out_red;
  logic [ChanW-1:0]  out_green;
  logic [ChanW-1:0]  out_blue;
  logic [ChanW-1:0]  out_alpha;

  rgba_scoreboard sb;
  bit             calm;         // suppresses idling on both sides
  int unsigned    sent;
  int unsigned    mode_writes;

  legacy_texel_to_rgba8 u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_texel_bytes (in_texel_bytes),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_red        (out_red),
    .out_green      (out_green),
    .out_blue       (out_blue),
    .out_alpha      (out_alpha)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // consumer back-pressure at random, with a probability of about 14 percent, unless calm
  always @(negedge clk) begin
    out_stall <= !calm && ($urandom_range(99) < 14);
  end

  // monitor: everything is sampled at the rising edge, the driver moves on the falling one
  always @(posedge clk) begin : monitor
    rgba_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got.red   = out_red;
        got.green = out_green;
        got.blue  = out_blue;
        got.alpha = out_alpha;
        sb.check_result(got);
      end
      // a request taken at this edge still sees the old mode
      if (in_valid && !in_stall) begin
        sb.note_request(in_texel_bytes);
      end
      if (cfg_valid && cfg_ready) begin
        sb.mode = cfg_data;
      end
    end
  end

  // send one texel request, with random idle cycles before it
  task automatic push_texel(input logic [TexelW-1:0] t);
    @(negedge clk);
    while (!calm && $urandom_range(99) < 14) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    in_texel_bytes <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  // stop sending and wait until every expected texel is back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending_rgba.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // write the mode register; only called with the pipe empty
  task automatic set_mode(input logic [ModeW-1:0] m);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= m;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    mode_writes++;
  endtask

  // mostly random texels, with some all-zero and all-one ones
  function automatic logic [TexelW-1:0] random_texel();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return TexelW'($urandom());
    endcase
  endfunction

  initial begin : stimulus
    logic [ModeW-1:0] m;
    sb             = new();
    clk            = 1'b0;
    rst_n          = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    in_valid       = 1'b0;
    in_texel_bytes = '0;
    calm           = 1'b0;
    sent           = 0;
    mode_writes    = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: the reset mode first, then every code including the unused 6 and 7
    push_texel(24'h123456);
    drain();
    for (int k = 0; k < 8; k++) begin
      set_mode(k[ModeW-1:0]);
      push_texel(24'h000000);
      push_texel(24'hFFFFFF);
      push_texel(24'hA5C35A);
      // hold the sender until the pipe is empty before the next write
      drain();
    end

    // random phases: each mode once in order, then random modes; one phase runs calm
    for (int p = 0; p < 12; p++) begin
      m = (p < 8) ? p[ModeW-1:0] : ModeW'($urandom_range(7));
      set_mode(m);
      calm = (p == 9);
      for (int i = 0; i < 100; i++) push_texel(random_texel());
      drain();
    end
    calm = 1'b0;

    repeat (10) @(posedge clk);
    $display("converted %0d texels over %0d mode writes, all eight mode codes",
             sent, mode_writes);
    $display("%0d results checked, %0d field mismatches, %0d left pending",
             sb.checked, sb.mismatches, sb.pending_rgba.size());
    if (sb.mismatches == 0 && sb.pending_rgba.size() == 0) begin
      $display("PASS legacy_texel_to_rgba8");
    end else begin
      $display("FAIL legacy_texel_to_rgba8");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin : watchdog
    #2ms;
    $display("FAIL legacy_texel_to_rgba8");
    $finish;
  end

endmodule
